// ===== rtl/rspb_pkg.sv =====
// ----------------------------------------------------------------------------
// RAID-5 stripe parity builder package
// Shared widths, constants and the stripe result type.
// ----------------------------------------------------------------------------
package rspb_pkg;

  localparam int BLOCK_BITS      = 20;
  localparam int DISKS           = 4;
  localparam int DATA_PER_STRIPE = DISKS - 1;
  localparam int COL_BITS        = $clog2(DISKS);
  localparam int SLOT_BITS       = $clog2(DATA_PER_STRIPE);

  typedef logic [BLOCK_BITS-1:0] block_t;
  typedef logic [COL_BITS-1:0]   col_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;

  // Phase zero places parity in the highest column.
  localparam col_t PHASE_START = '0;

  typedef struct packed {
    block_t [DISKS-1:0] chunk;
    col_t               parity_column;
    logic               final_stripe;
  } stripe_t;

endpackage

// ===== rtl/rspb_if.sv =====
// ----------------------------------------------------------------------------
// RAID-5 stripe parity builder channels
// Valid/ready channels for the data block input and the stripe output.
// ----------------------------------------------------------------------------
interface rspb_in_if
  import rspb_pkg::*;
();
  logic   valid;
  logic   ready;
  block_t data_block;
  logic   last_block;

  modport source (output valid, output data_block, output last_block, input ready);
  modport sink   (input valid, input data_block, input last_block, output ready);
endinterface

interface rspb_out_if
  import rspb_pkg::*;
();
  logic   valid;
  logic   ready;
  block_t disk0_chunk;
  block_t disk1_chunk;
  block_t disk2_chunk;
  block_t disk3_chunk;
  col_t   parity_column;
  logic   final_stripe;

  modport source (output valid, output disk0_chunk, output disk1_chunk,
                  output disk2_chunk, output disk3_chunk, output parity_column,
                  output final_stripe, input ready);
  modport sink   (input valid, input disk0_chunk, input disk1_chunk,
                  input disk2_chunk, input disk3_chunk, input parity_column,
                  input final_stripe, output ready);
endinterface

// ===== rtl/raid5_stripe_parity_builder_unit.sv =====
// ----------------------------------------------------------------------------
// RAID-5 stripe parity builder
// Groups data blocks three to a stripe over four disks with rotating parity.
// ----------------------------------------------------------------------------
// Usage:
// Data blocks enter on blk_in, one beat per block, with last_block marking the
// final block of a message. Every third block, or any block flagged last,
// closes a stripe, and one beat leaves on stripe_out carrying the four disk
// chunks, the parity column and the final-stripe flag. Other beats produce
// no output. Parity rotates through columns 3, 2, 1, 0 and starts again at
// column 3 after a flagged block. A short stripe fills its missing data
// slots with zeros.
// A closing beat's stripe is registered into the output register, or into the
// skid register if that is still held. Throughput: one input beat per cycle
// while blk_in.ready is high, set by the single stage of XOR accumulate and
// column steering between the slot registers and the output register.
// Stalls: the output register is backed by a one-entry skid register, so
// blk_in keeps taking beats while a stripe waits; blk_in.ready drops only
// when both hold a stripe, and rises once the receiver takes one.
// Reset (rst, synchronous): the stripe restarts empty with parity in column
// 3, and both output entries are emptied.
// ----------------------------------------------------------------------------
module raid5_stripe_parity_builder_unit
  import rspb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  rspb_in_if.sink     blk_in,
  rspb_out_if.source  stripe_out
);

  // Open stripe state.
  col_t   stripe_phase;
  slot_t  slot_count;
  block_t held_blocks [2];
  block_t parity_accumulator;

  // Output register and its skid entry.
  stripe_t out_reg;
  logic    out_valid;
  stripe_t skid_reg;
  logic    skid_valid;

  logic    accept;
  logic    pop;
  logic    closes;
  block_t  parity;
  block_t  data [DATA_PER_STRIPE];
  col_t    pcol;
  stripe_t result;

  assign accept = blk_in.valid && blk_in.ready;
  assign pop    = out_valid && stripe_out.ready;

  // The stripe closes on the third block or on a flagged block.
  assign closes = blk_in.last_block || (slot_count == slot_t'(DATA_PER_STRIPE - 1));
  assign parity = parity_accumulator ^ blk_in.data_block;
  // Parity column is 3 - phase, which for two bits is the inverted phase.
  assign pcol   = ~stripe_phase;

  always_comb begin
    // Only slots below the fill count are read; the rest are zero.
    data[0] = '0;
    data[1] = '0;
    data[2] = '0;
    unique case (slot_count)
      slot_t'(0): begin
        data[0] = blk_in.data_block;
      end
      slot_t'(1): begin
        data[0] = held_blocks[0];
        data[1] = blk_in.data_block;
      end
      default: begin
        data[0] = held_blocks[0];
        data[1] = held_blocks[1];
        data[2] = blk_in.data_block;
      end
    endcase
  end

  always_comb begin
    result.parity_column = pcol;
    result.final_stripe  = blk_in.last_block;
    // Data fills the non-parity columns left to right.
    unique case (pcol)
      col_t'(3): begin
        result.chunk = {parity, data[2], data[1], data[0]};
      end
      col_t'(2): begin
        result.chunk = {data[2], parity, data[1], data[0]};
      end
      col_t'(1): begin
        result.chunk = {data[2], data[1], parity, data[0]};
      end
      default: begin
        result.chunk = {data[2], data[1], data[0], parity};
      end
    endcase
  end

  // Stripe assembly.
  always_ff @(posedge clk) begin
    if (rst) begin
      stripe_phase       <= PHASE_START;
      slot_count         <= '0;
      parity_accumulator <= '0;
    end else if (accept) begin
      if (closes) begin
        slot_count         <= '0;
        parity_accumulator <= '0;
        stripe_phase       <= blk_in.last_block ? PHASE_START : stripe_phase + col_t'(1);
      end else begin
        slot_count         <= slot_count + slot_t'(1);
        parity_accumulator <= parity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !closes) begin
      held_blocks[slot_count[0]] <= blk_in.data_block;
    end
  end

  // Output register with skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end
    end else if (accept && closes) begin
      if (!out_valid || pop) begin
        out_reg   <= result;
        out_valid <= 1'b1;
      end else begin
        skid_reg   <= result;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign blk_in.ready             = !skid_valid;
  assign stripe_out.valid         = out_valid;
  assign stripe_out.disk0_chunk   = out_reg.chunk[0];
  assign stripe_out.disk1_chunk   = out_reg.chunk[1];
  assign stripe_out.disk2_chunk   = out_reg.chunk[2];
  assign stripe_out.disk3_chunk   = out_reg.chunk[3];
  assign stripe_out.parity_column = out_reg.parity_column;
  assign stripe_out.final_stripe  = out_reg.final_stripe;

  // The skid entry is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a stripe while the output register is empty");

  // The fill count never reaches a full stripe's worth of held blocks.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot_count != slot_t'(DATA_PER_STRIPE))
    else $error("slot count out of range");

  // A flagged block restarts the rotation with an empty stripe.
  a_flush_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && blk_in.last_block) |=>
      (slot_count == '0 && stripe_phase == PHASE_START && parity_accumulator == '0))
    else $error("stripe not restarted after last block");

  // Every closing beat leaves a stripe in one of the two output entries.
  a_close_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && closes) |=> out_valid)
    else $error("closed stripe was not registered");

endmodule
